// File: rtl/bsst_pkg.sv
// Shared types and constants for the bounded set span tracker.
`default_nettype none
package bsst_pkg;

  localparam int COUNT_W  = 11;   // held count and capacity register
  localparam int VALUE_W  = 31;   // stored (non-negative) value
  localparam int IN_W     = 32;   // input value, two's complement
  localparam int STATUS_W = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int MIN_PAIR = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NEGATIVE = 2'd2
  } status_t;

  // Register index sits at paddr[2] (byte address 4*i).
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/bsst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bsst_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/bounded_set_span_tracker_top.sv
// Top level of the bounded set span tracker: sequencer, running spans and store.
`default_nettype none
// Takes one number per transfer and adds it to a store of up to
// min(capacity, CAPACITY) values; a full store refuses it with status 1, a
// negative number with status 2 (full wins), and a refused number changes
// nothing. Every transfer returns one result with the count and the shortest
// and longest span over the held values (both 0 while fewer than two are
// held). An accepted number is compared with every held value through a
// single absolute-difference unit fed by the store's one read port, one entry
// per cycle in ST_SCAN, then passes ST_DRAIN and ST_WRITE before ST_DONE
// (only ST_WRITE into an empty store; a refused number goes straight to
// ST_DONE), and the next number is taken the cycle after the result is
// transferred, so no new number is taken while one is in flight. The store
// needs no clearing after reset; only entries below the count are ever read.
// Configuration: one register, capacity, at byte address 0 of the APB port.
module bounded_set_span_tracker_top
  import bsst_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [IN_W-1:0] value,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [COUNT_W-1:0]       count,
  output logic                     enough_numbers,
  output logic [VALUE_W-1:0]       shortest_span,
  output logic [VALUE_W-1:0]       longest_span
);

  localparam int AW = $clog2(CAPACITY);

  state_t state, state_next;

  logic [COUNT_W-1:0] capacity;
  logic [COUNT_W-1:0] held_count;
  logic [VALUE_W-1:0] smallest_value;
  logic [VALUE_W-1:0] largest_value;
  logic [VALUE_W-1:0] min_gap;
  logic [VALUE_W-1:0] cur_value;
  logic [COUNT_W-1:0] idx;
  logic               rd_pend;
  status_t            result_status;

  logic               in_xfer;
  logic               out_xfer;
  logic               is_full;
  logic [VALUE_W-1:0] rdata;
  logic [VALUE_W-1:0] diff;
  logic [AW+COUNT_W-1:0] waddr_wide;
  logic [AW+COUNT_W-1:0] raddr_wide;
  logic               ram_we;

  // APB: always ready, register index at paddr[2]
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[COUNT_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state == ST_DONE);
  assign out_xfer  = out_valid && !out_stall;

  // effective limit saturates at CAPACITY
  assign is_full = (held_count >= capacity) || (32'(held_count) >= CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (is_full || value[IN_W-1]) begin
            state_next = ST_DONE;
          end else if (held_count == '0) begin
            state_next = ST_WRITE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (idx + 1'b1 == held_count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_xfer) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      idx     <= '0;
    end else begin
      rd_pend <= (state == ST_SCAN);
      if (state == ST_SCAN) begin
        idx <= idx + 1'b1;
      end else begin
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_value <= value[VALUE_W-1:0];
      if (is_full) begin
        result_status <= STATUS_FULL;
      end else if (value[IN_W-1]) begin
        result_status <= STATUS_NEGATIVE;
      end else begin
        result_status <= STATUS_ACCEPTED;
      end
    end
  end

  // shared unit: absolute difference against the entry just read
  assign diff = (cur_value >= rdata) ? (cur_value - rdata) : (rdata - cur_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= '0;
      smallest_value <= '0;
      largest_value  <= '0;
      min_gap        <= '1;
    end else begin
      if (rd_pend && diff < min_gap) begin
        min_gap <= diff;
      end
      if (state == ST_WRITE) begin
        held_count <= held_count + 1'b1;
        if (held_count == '0) begin
          smallest_value <= cur_value;
          largest_value  <= cur_value;
        end else begin
          if (cur_value < smallest_value) begin
            smallest_value <= cur_value;
          end
          if (cur_value > largest_value) begin
            largest_value <= cur_value;
          end
        end
      end
    end
  end

  // widen before narrowing so any CAPACITY fits the store address
  assign waddr_wide = {{AW{1'b0}}, held_count};
  assign raddr_wide = {{AW{1'b0}}, idx};
  assign ram_we     = (state == ST_WRITE);

  bsst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_wide[AW-1:0]),
    .wdata (cur_value),
    .raddr (raddr_wide[AW-1:0]),
    .rdata (rdata)
  );

  // result fields read straight from registers that hold while DONE
  assign status         = result_status;
  assign count          = held_count;
  assign enough_numbers = (held_count >= COUNT_W'(MIN_PAIR));
  assign shortest_span  = enough_numbers ? min_gap : '0;
  assign longest_span   = enough_numbers ? (largest_value - smallest_value) : '0;

endmodule
`default_nettype wire

// File: rtl/bsst_checker.sv
// Port-level checks for the bounded set span tracker, bound to the top level.
`default_nettype none
module bsst_checker
  import bsst_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [COUNT_W-1:0]  count,
  input wire logic                enough_numbers,
  input wire logic [VALUE_W-1:0]  shortest_span,
  input wire logic [VALUE_W-1:0]  longest_span
);

  // one item in flight: no new transfer while a result is pending
  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_ACCEPTED || status == STATUS_FULL ||
                   status == STATUS_NEGATIVE))
    else $error("unknown status code");

  a_enough_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (enough_numbers == (count >= COUNT_W'(MIN_PAIR))))
    else $error("enough_numbers disagrees with count");

  a_spans_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !enough_numbers) |-> (shortest_span == '0 && longest_span == '0))
    else $error("spans not zero with fewer than two values");

  a_shortest_le_longest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && enough_numbers) |-> (shortest_span <= longest_span))
    else $error("shortest span exceeds longest span");

endmodule

bind bounded_set_span_tracker_top bsst_checker u_bsst_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .count          (count),
  .enough_numbers (enough_numbers),
  .shortest_span  (shortest_span),
  .longest_span   (longest_span)
);
`default_nettype wire
